/* sv/cbts_pkg.sv */
// Shared widths, constants and types for the CAN bit timing search block.
package cbts_pkg;

    localparam int CLK_W       = 32;
    localparam int BITRATE_W   = 20;
    localparam int PRE_OUT_W   = 11;
    localparam int SEG1_W      = 4;
    localparam int SEG2_W      = 3;
    localparam int JW_W        = 2;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam int PERMILLE    = 1000;
    localparam int ERR_LIMIT   = 5;
    localparam int PERMILLE_W  = 10;

    localparam logic [CLK_W-1:0] CLK_RESET = 32'd36000000;

    typedef struct packed {
        logic [OUT_TDATA_W-PRE_OUT_W-SEG1_W-SEG2_W-JW_W-1:0] pad;
        logic [JW_W-1:0]      jump_width_code;
        logic [SEG2_W-1:0]    seg2_code;
        logic [SEG1_W-1:0]    seg1_code;
        logic [PRE_OUT_W-1:0] prescaler_value;
    } t_result;

    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctl;

endpackage

/* sv/cbts_div.sv */
// Serial restoring divider: one quotient bit per cycle.
module cbts_div #(
    parameter int DVW = 31
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [cbts_pkg::CLK_W-1:0] i_dividend,
    input  logic [DVW-1:0]           i_divisor,
    output logic                     o_done,
    output logic [cbts_pkg::CLK_W-1:0] o_quotient
);
    import cbts_pkg::*;

    localparam int CW = $clog2(CLK_W);

    logic [DVW-1:0]   r_rem, n_rem;
    logic [CLK_W-1:0] r_quo, n_quo;
    logic [DVW-1:0]   r_dvs, n_dvs;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;

    logic [DVW:0] trial;
    logic         ge;

    always_comb begin
        trial  = {r_rem, r_quo[CLK_W-1]};
        ge     = trial >= {1'b0, r_dvs};
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
            n_cnt  = CW'(CLK_W - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = ge ? DVW'(trial - {1'b0, r_dvs}) : trial[DVW-1:0];
            n_quo = {r_quo[CLK_W-2:0], ge};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
        r_cnt <= n_cnt;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* sv/can_bit_timing_search_top.sv */
// CAN bit timing search: top level with sequencer, error check and output register.
// Takes a bitrate beat and tries prescalers 1..PRESCALER_MAX in order; each try runs
// a serial division of the clock by prescaler*bitrate, and the permille check runs
// after it when the quanta fit. A zero bitrate goes straight to the finish state
// and gives a failure result. The input is ready again once the result is in
// the output register; a new beat may be taken while that result waits.
module can_bit_timing_search_top #(
    parameter int PRESCALER_MAX = 1024,
    parameter int SEG1_LIMIT    = 16,
    parameter int SEG2_MAX      = 8,
    parameter int JUMP_MAX      = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [cbts_pkg::CLK_W-1:0]         i_cfg_wr_data,   // clock_hz
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [cbts_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,  // [19:0] bitrate_bps
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [10:0] prescaler_value, [14:11] seg1_code, [17:15] seg2_code, [19:18] jump_width_code
    output logic [cbts_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    output logic                               o_m_axis_tuser   // status
);
    import cbts_pkg::*;

    localparam int PW   = $clog2(PRESCALER_MAX + 1);
    localparam int MW   = BITRATE_W + PW;
    localparam int TMAX = SEG1_LIMIT + SEG2_MAX;
    localparam int TW   = $clog2(TMAX + 1);
    localparam int SW   = TW + 2;
    localparam int DNW  = MW + TW;
    localparam int CKW  = CLK_W + PERMILLE_W;
    localparam int SCW  = DNW + PERMILLE_W + 1;
    localparam int CMW  = (CKW > SCW) ? CKW : SCW;

    localparam logic signed [SW-1:0] C_ONE  = SW'(1);
    localparam logic signed [SW-1:0] C_TWO  = SW'(2);
    localparam logic signed [SW-1:0] C_S2M  = SW'(SEG2_MAX);
    localparam logic signed [SW-1:0] C_S1M  = SW'(SEG1_LIMIT - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIVGO = 3'd1;
    localparam logic [2:0] ST_DIVW  = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_SCALE = 3'd4;
    localparam logic [2:0] ST_CHECK = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    logic [2:0]           r_state, n_state;
    logic [CLK_W-1:0]     r_clk, n_clk;
    logic [BITRATE_W-1:0] r_br, n_br;
    logic [PW-1:0]        r_pre, n_pre;
    logic [MW-1:0]        r_m, n_m;
    logic [CMW-1:0]       r_ck1k, n_ck1k;
    logic [TW-1:0]        r_tot, n_tot;
    logic signed [SW-1:0] r_s1, n_s1;
    logic signed [SW-1:0] r_s2, n_s2;
    logic [DNW-1:0]       r_den, n_den;
    logic [CMW-1:0]       r_lo, n_lo;
    logic [CMW-1:0]       r_hi, n_hi;
    logic                 r_fail, n_fail;
    logic                 r_out_valid, n_out_valid;
    t_result              r_out_data, n_out_data;
    logic                 r_out_user, n_out_user;

    t_div_ctl             div_ctl;
    logic [CLK_W-1:0]     div_quo;

    logic signed [SW-1:0] q_s, lo_b, lo_c, s1_lo, s1_hi;
    logic                 tot_ok, seg_ok;
    logic                 s_accept;
    t_result              res;

    assign div_ctl.start = (r_state == ST_DIVGO);

    cbts_div #(
        .DVW (MW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_ctl.start),
        .i_dividend (r_clk),
        .i_divisor  (r_m),
        .o_done     (div_ctl.done),
        .o_quotient (div_quo)
    );

    // closed-form smallest seg1 for a given quanta count
    always_comb begin
        tot_ok = (div_quo != '0) && (div_quo <= CLK_W'(TMAX));
        q_s    = $signed(SW'(div_quo[TW-1:0])) - C_ONE;
        lo_b   = q_s - C_S2M;
        lo_c   = (q_s + C_ONE) >>> 1;
        s1_lo  = C_TWO;
        if (lo_b > s1_lo) s1_lo = lo_b;
        if (lo_c > s1_lo) s1_lo = lo_c;
        s1_hi  = q_s - C_TWO;
        if (C_S1M < s1_hi) s1_hi = C_S1M;
        seg_ok = tot_ok && (s1_lo <= s1_hi);
    end

    always_comb begin
        res = '0;
        if (!r_fail) begin
            res.prescaler_value = PRE_OUT_W'(r_pre);
            res.seg1_code       = SEG1_W'(r_s1 - C_ONE);
            res.seg2_code       = SEG2_W'(r_s2 - C_ONE);
            if (int'(r_s2) - 1 > JUMP_MAX) begin
                res.jump_width_code = JW_W'(JUMP_MAX - 1);
            end else begin
                res.jump_width_code = JW_W'(r_s2 - C_TWO);
            end
        end
    end

    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_state     = r_state;
        n_clk       = i_cfg_wr_en ? i_cfg_wr_data : r_clk;
        n_br        = r_br;
        n_pre       = r_pre;
        n_m         = r_m;
        n_ck1k      = r_ck1k;
        n_tot       = r_tot;
        n_s1        = r_s1;
        n_s2        = r_s2;
        n_den       = r_den;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_fail      = r_fail;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_br   = i_s_axis_tdata[BITRATE_W-1:0];
                    n_pre  = PW'(1);
                    n_m    = MW'(i_s_axis_tdata[BITRATE_W-1:0]);
                    n_ck1k = CMW'(r_clk) * CMW'(PERMILLE);
                    n_fail = 1'b1;
                    if (i_s_axis_tdata[BITRATE_W-1:0] == '0) begin
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_DIVGO;
                    end
                end
            end
            ST_DIVGO: begin
                n_state = ST_DIVW;
            end
            ST_DIVW: begin
                if (div_ctl.done) begin
                    n_tot = div_quo[TW-1:0];
                    n_s1  = s1_lo;
                    n_s2  = q_s - s1_lo;
                    if (seg_ok) begin
                        n_state = ST_MUL;
                    end else if (r_pre == PW'(PRESCALER_MAX)) begin
                        n_state = ST_FIN;
                    end else begin
                        n_pre   = r_pre + PW'(1);
                        n_m     = r_m + MW'(r_br);
                        n_state = ST_DIVGO;
                    end
                end
            end
            ST_MUL: begin
                n_den   = DNW'(r_m) * DNW'(r_tot);
                n_state = ST_SCALE;
            end
            ST_SCALE: begin
                n_lo    = CMW'(r_den) * CMW'(PERMILLE - ERR_LIMIT);
                n_hi    = CMW'(r_den) * CMW'(PERMILLE + ERR_LIMIT + 1);
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if ((r_lo <= r_ck1k) && (r_ck1k < r_hi)) begin
                    n_fail  = 1'b0;
                    n_state = ST_FIN;
                end else if (r_pre == PW'(PRESCALER_MAX)) begin
                    n_state = ST_FIN;
                end else begin
                    n_pre   = r_pre + PW'(1);
                    n_m     = r_m + MW'(r_br);
                    n_state = ST_DIVGO;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = res;
                    n_out_user  = r_fail;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_clk       <= CLK_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clk       <= n_clk;
            r_out_valid <= n_out_valid;
        end
        r_br       <= n_br;
        r_pre      <= n_pre;
        r_m        <= n_m;
        r_ck1k     <= n_ck1k;
        r_tot      <= n_tot;
        r_s1       <= n_s1;
        r_s2       <= n_s2;
        r_den      <= n_den;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_fail     <= n_fail;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("failure beat carries nonzero timing fields");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_ctl.done |-> r_state == ST_DIVW)
        else $error("divider finished outside wait state");

    a_pre_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CHECK |-> (r_pre != '0) && (r_pre <= PW'(PRESCALER_MAX)))
        else $error("prescaler out of range at check");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_axis_tready)
        else $error("input ready right after accepting a beat");

    a_ok_prescaler: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata[PRE_OUT_W-1:0] != '0)
        else $error("ok result with zero prescaler");

endmodule
